FILE: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes of the generational handle allocator: request
// modes, response status codes and the fixed handle field width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

    // Width of the handle fields on both channels
    localparam int unsigned HANDLE_W = 16;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    // Request modes
    localparam mode_t MODE_CREATE  = 2'd0;
    localparam mode_t MODE_DESTROY = 2'd1;
    localparam mode_t MODE_QUERY   = 2'd2;

    // Response status codes
    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_DEAD = 2'd2;

endpackage

FILE: rtl/gha_req_if.sv
// ----------------------------------------------------------------------------
// gha_req_if
// Request channel: valid/ready handshake carrying the mode and handle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gha_req_if;

    logic                            valid;
    logic                            ready;
    gha_pkg::mode_t                  mode;
    logic [gha_pkg::HANDLE_W-1:0]    handle_in;

    modport source (output valid, output mode, output handle_in, input ready);
    modport sink   (input valid, input mode, input handle_in, output ready);

endinterface

FILE: rtl/gha_rsp_if.sv
// ----------------------------------------------------------------------------
// gha_rsp_if
// Response channel: valid/ready handshake carrying handle, alive and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gha_rsp_if;

    logic                            valid;
    logic                            ready;
    logic [gha_pkg::HANDLE_W-1:0]    handle_out;
    logic                            alive;
    gha_pkg::status_t                status;

    modport source (output valid, output handle_out, output alive, output status,
                    input ready);
    modport sink   (input valid, input handle_out, input alive, input status,
                    output ready);

endinterface

FILE: rtl/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Stage one registers a request beat; the response register holds its result.
// Throughput: one request per cycle unless rsp.ready stalls; two registered
// generation memory read ports with same-cycle write bypass set this figure.
// Reset: stack count, fresh-index counter (to one) and valid flags clear at
// once; no memory clearing pass, the fresh-index counter bounds which
// generation entries are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator_core #(
    parameter int unsigned INDEX_BITS = 10,
    parameter int unsigned GEN_BITS   = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    gha_req_if.sink    req,
    gha_rsp_if.source  rsp
);

    localparam int unsigned Depth   = 1 << INDEX_BITS;
    localparam int unsigned CntW    = INDEX_BITS + 1;
    localparam int unsigned HandleW = gha_pkg::HANDLE_W;
    localparam int unsigned FullW   = INDEX_BITS + GEN_BITS;
    localparam int unsigned WideW   = (FullW > HandleW) ? FullW : HandleW;
    localparam logic [INDEX_BITS-1:0] FreshLimit = INDEX_BITS'(Depth - 1);
    localparam logic [CntW-1:0]       StackFull  = CntW'(Depth);

    // Memories
    logic [GEN_BITS-1:0]   gen_mem [Depth];
    logic [INDEX_BITS-1:0] stk_mem [Depth];

    // Control state
    logic                  s1_valid_reg, s1_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] fresh_reg, fresh_next;
    logic [INDEX_BITS-1:0] top_reg, top_next;

    // Stage one payload and read data
    gha_pkg::mode_t        s1_mode_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic [GEN_BITS-1:0]   s1_gen_reg;
    logic                  byp_h_reg;
    logic                  byp_t_reg;
    logic [GEN_BITS-1:0]   byp_gen_reg;
    logic [GEN_BITS-1:0]   gen_h_rd_reg;
    logic [GEN_BITS-1:0]   gen_t_rd_reg;
    logic [INDEX_BITS-1:0] stk_rd_reg;

    // Response register
    logic [HandleW-1:0]    hout_reg;
    logic                  alive_reg;
    gha_pkg::status_t      status_reg;

    // Input decode
    logic [WideW-1:0]      wide_in;
    logic [INDEX_BITS-1:0] in_idx;
    logic [GEN_BITS-1:0]   in_gen;
    logic                  in_ready;
    logic                  in_fire;

    // Stage one logic
    logic [GEN_BITS-1:0]   gen_h;
    logic [GEN_BITS-1:0]   gen_t;
    logic                  alive_h;
    logic [FullW-1:0]      res_handle;
    logic                  res_alive;
    gha_pkg::status_t      res_status;
    logic [CntW-1:0]       cnt_upd;
    logic [INDEX_BITS-1:0] fresh_upd;
    logic [INDEX_BITS-1:0] top_upd;
    logic                  gw_en;
    logic [INDEX_BITS-1:0] gw_addr;
    logic [GEN_BITS-1:0]   gw_data;
    logic                  sw_en;
    logic                  pop;
    logic                  s1_adv;
    logic                  gen_wr_en;
    logic                  stk_wr_en;
    logic [CntW-1:0]       cnt_rd;
    logic [INDEX_BITS-1:0] stk_rd_addr;

    // Split the incoming handle into index and generation
    assign wide_in = WideW'(req.handle_in);
    assign in_idx  = wide_in[INDEX_BITS-1:0];
    assign in_gen  = wide_in[FullW-1:INDEX_BITS];

    // Handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && in_ready;
    assign req.ready = in_ready;

    // Resolve the operation held in stage one
    always_comb
    begin
        gen_h      = byp_h_reg ? byp_gen_reg : gen_h_rd_reg;
        gen_t      = byp_t_reg ? byp_gen_reg : gen_t_rd_reg;
        alive_h    = (s1_idx_reg != '0) && (s1_idx_reg < fresh_reg)
                     && (gen_h == s1_gen_reg);
        res_handle = '0;
        res_alive  = 1'b0;
        res_status = gha_pkg::ST_DONE;
        cnt_upd    = cnt_reg;
        fresh_upd  = fresh_reg;
        top_upd    = top_reg;
        gw_en      = 1'b0;
        gw_addr    = s1_idx_reg;
        gw_data    = gen_h + GEN_BITS'(1);
        sw_en      = 1'b0;
        pop        = 1'b0;
        case (s1_mode_reg)
            gha_pkg::MODE_CREATE:
            begin
                if (cnt_reg != '0)
                begin
                    // Reuse the most recently freed index
                    pop        = 1'b1;
                    res_handle = {gen_t, top_reg};
                    cnt_upd    = cnt_reg - CntW'(1);
                    top_upd    = stk_rd_reg;
                end
                else if (fresh_reg >= FreshLimit)
                begin
                    res_status = gha_pkg::ST_FULL;
                end
                else
                begin
                    // Grant a fresh index at generation zero
                    res_handle = {GEN_BITS'(0), fresh_reg};
                    gw_en      = 1'b1;
                    gw_addr    = fresh_reg;
                    gw_data    = '0;
                    fresh_upd  = fresh_reg + INDEX_BITS'(1);
                end
            end
            gha_pkg::MODE_DESTROY:
            begin
                if (alive_h)
                begin
                    res_alive = 1'b1;
                    gw_en     = 1'b1;
                    if (cnt_reg != StackFull)
                    begin
                        sw_en   = 1'b1;
                        cnt_upd = cnt_reg + CntW'(1);
                        top_upd = s1_idx_reg;
                    end
                end
                else
                begin
                    res_status = gha_pkg::ST_DEAD;
                end
            end
            gha_pkg::MODE_QUERY:
            begin
                res_alive = alive_h;
            end
            default:
            begin
            end
        endcase
    end

    // Commit state only when stage one moves on
    assign gen_wr_en   = s1_adv && gw_en;
    assign stk_wr_en   = s1_adv && sw_en;
    assign cnt_next    = s1_adv ? cnt_upd : cnt_reg;
    assign fresh_next  = s1_adv ? fresh_upd : fresh_reg;
    assign top_next    = s1_adv ? top_upd : top_reg;
    assign cnt_rd      = cnt_next - CntW'(2);
    assign stk_rd_addr = cnt_rd[INDEX_BITS-1:0];

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // Generation memory: one write port, two read ports loaded on accept
    always_ff @(posedge clk)
    begin
        if (gen_wr_en)
        begin
            gen_mem[gw_addr] <= gw_data;
        end
        if (in_fire)
        begin
            gen_h_rd_reg <= gen_mem[in_idx];
            gen_t_rd_reg <= gen_mem[top_next];
        end
    end

    // Free stack memory: push on destroy, read the entry below the top
    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[cnt_reg[INDEX_BITS-1:0]] <= s1_idx_reg;
        end
        stk_rd_reg <= stk_mem[stk_rd_addr];
    end

    // Capture the request beat and bypass the write of the same cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg <= req.mode;
            s1_idx_reg  <= in_idx;
            s1_gen_reg  <= in_gen;
            byp_h_reg   <= gen_wr_en && (gw_addr == in_idx);
            byp_t_reg   <= gen_wr_en && (gw_addr == top_next);
            byp_gen_reg <= gw_data;
        end
    end

    // Load the response beat
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hout_reg   <= HandleW'(res_handle);
            alive_reg  <= res_alive;
            status_reg <= res_status;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            fresh_reg     <= INDEX_BITS'(1);
            top_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            top_reg       <= top_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = hout_reg;
    assign rsp.alive      = alive_reg;
    assign rsp.status     = status_reg;

`ifndef SYNTHESIS
    // Stack never holds more entries than the index space
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= StackFull)
        else $error("free stack count out of range");

    // Fresh counter stays past the reserved index and within the limit
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg != '0) && (fresh_reg <= FreshLimit))
        else $error("fresh index counter out of range");

    // A committed pop drops the stack count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && pop) |=> (cnt_reg == $past(cnt_reg) - CntW'(1)))
        else $error("pop did not decrement stack count");
`endif

endmodule
